// ===== rtl/tupe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tupe_pkg;

  // palette depth default and fixed tile geometry
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int TILE_BITS           = 3;
  localparam logic [TILE_BITS-1:0] TILE_LAST = '1;

  // config register file
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int DIM_W      = 15;
  localparam int TILES_W    = 12;
  localparam int POS_W      = TILES_W + TILE_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_X            = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_Y            = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_TILES_ACROSS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_TILES_DOWN   = 3'd5;

  localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = 15'd8;
  localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = 15'd8;
  localparam logic [TILES_W-1:0] TILES_RST        = 12'd1;

  // item commands
  localparam logic CMD_PALETTE_WRITE = 1'b0;
  localparam logic CMD_PIXEL         = 1'b1;

  // key colour of palette entry zero
  localparam logic [7:0] KEY_FIRST  = 8'hF8;
  localparam logic [7:0] KEY_SECOND = 8'h00;
  localparam logic [7:0] KEY_THIRD  = 8'hF8;

  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam int ADDR_W = 30;

  typedef struct packed {
    logic       command;
    logic [7:0] index;
    logic [7:0] color_first;
    logic [7:0] color_second;
    logic [7:0] color_third;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [7:0]        out_first;
    logic [7:0]        out_second;
    logic [7:0]        out_third;
    logic [7:0]        alpha;
    logic              cell_done;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/tile_unswizzle_palette_expand_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake           payload
// in_       input      in_valid/in_ready   in_item_t   palette write or pixel index
// out_      output     out_valid/out_ready out_item_t  address, colour, alpha, cell_done
// cfg_      input      cfg_we              cfg_idx, cfg_data  register write, no wait
//
// one item per cycle sustained while out_ready stays high; a taken pixel passes
// palette read and position capture, address multiply, then add and bound compare
// into the output register
// synchronous active-low reset clears the pipe valids, tile counters and key flag,
// and loads the config registers with reset values; the palette needs no clearing
// out_ready low backs up one stage at a time; in_ready only falls when all
// three stages hold an item

module tile_unswizzle_palette_expand_unit
  import tupe_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,

  input  wire                   in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,

  output logic                  out_valid,
  input  wire                   out_ready,
  output out_item_t             out_data,

  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_idx,
  input  wire [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]   image_width_r, image_height_r, cell_x_r, cell_y_r;
  logic [TILES_W-1:0] tiles_across_r, tiles_down_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
      cell_x_r       <= '0;
      cell_y_r       <= '0;
      tiles_across_r <= TILES_RST;
      tiles_down_r   <= TILES_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_IMAGE_WIDTH:       image_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT:      image_height_r <= cfg_data;
        CFG_CELL_X:            cell_x_r       <= cfg_data;
        CFG_CELL_Y:            cell_y_r       <= cfg_data;
        CFG_CELL_TILES_ACROSS: tiles_across_r <= cfg_data[TILES_W-1:0];
        CFG_CELL_TILES_DOWN:   tiles_down_r   <= cfg_data[TILES_W-1:0];
        default: ;  // unknown register index, write dropped
      endcase
    end
  end

  // image pixel count, kept up to date in the background
  logic [2*DIM_W-1:0] limit_r;
  always_ff @(posedge clk) begin
    limit_r <= (2*DIM_W)'(image_width_r) * (2*DIM_W)'(image_height_r);
  end

  // ---------------------------------------------------------------------------
  // pipeline handshake
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_free, s2_go, s1_go;
  logic in_acc, pix_acc, wr_acc;

  assign out_free = !out_v_r || out_ready;
  assign s2_go    = s2_v_r && out_free;
  assign s1_go    = s1_v_r && (!s2_v_r || s2_go);
  assign in_ready = !s1_v_r || s1_go;
  assign in_acc   = in_valid && in_ready;
  assign pix_acc  = in_acc && (in_data.command == CMD_PIXEL);
  assign wr_acc   = in_acc && (in_data.command == CMD_PALETTE_WRITE);

  // ---------------------------------------------------------------------------
  // tile position counters, stepped on every accepted pixel
  // ---------------------------------------------------------------------------
  logic [TILE_BITS-1:0] in_col_r, in_row_r, in_col_nxt, in_row_nxt;
  logic [TILES_W-1:0]   tile_col_r, tile_row_r, tile_col_nxt, tile_row_nxt;
  logic                 last_col, last_row, cell_done;

  // a zero count compares like a count of one
  assign last_col  = ({1'b0, tile_col_r} + 13'd1) >= {1'b0, tiles_across_r};
  assign last_row  = ({1'b0, tile_row_r} + 13'd1) >= {1'b0, tiles_down_r};
  assign cell_done = last_col && last_row && (in_col_r == TILE_LAST) && (in_row_r == TILE_LAST);

  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    tile_col_nxt = tile_col_r;
    tile_row_nxt = tile_row_r;
    if (in_col_r != TILE_LAST) begin
      in_col_nxt = in_col_r + 1'b1;
    end else begin
      in_col_nxt = '0;
      if (in_row_r != TILE_LAST) begin
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_row_nxt = '0;
        if (!last_col) begin
          tile_col_nxt = tile_col_r + 1'b1;
        end else begin
          tile_col_nxt = '0;
          tile_row_nxt = last_row ? '0 : tile_row_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      tile_col_r <= '0;
      tile_row_r <= '0;
    end else if (pix_acc) begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      tile_col_r <= tile_col_nxt;
      tile_row_r <= tile_row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // palette memory and key flag
  // ---------------------------------------------------------------------------
  logic [23:0] palette_mem [PALETTE_ENTRIES];
  logic [23:0] pal_rd_r;
  logic        key_r;
  logic        idx_in_range;

  assign idx_in_range = {1'b0, in_data.index} < PAL_LIMIT;

  always_ff @(posedge clk) begin
    if (wr_acc && idx_in_range) begin
      palette_mem[in_data.index[PAL_AW-1:0]] <=
        {in_data.color_first, in_data.color_second, in_data.color_third};
    end
    if (pix_acc) begin
      pal_rd_r <= palette_mem[in_data.index[PAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= 1'b0;
    end else if (wr_acc && (in_data.index == 8'd0)) begin
      key_r <= (in_data.color_first == KEY_FIRST) && (in_data.color_second == KEY_SECOND)
            && (in_data.color_third == KEY_THIRD);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: captured position, palette read in flight
  // ---------------------------------------------------------------------------
  logic [DIM_W:0] s1_colsum_r, s1_row_r;
  logic           s1_in_range_r, s1_clear_r, s1_done_r;

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_colsum_r   <= {1'b0, cell_x_r} + {1'b0, tile_col_r, in_col_r};
      s1_row_r      <= {1'b0, cell_y_r} + {1'b0, tile_row_r, in_row_r};
      s1_in_range_r <= idx_in_range;
      s1_clear_r    <= (in_data.index == 8'd0) && key_r;
      s1_done_r     <= cell_done;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: row offset product
  // ---------------------------------------------------------------------------
  logic [DIM_W+DIM_W:0] s2_prod_r;
  logic [DIM_W:0]       s2_colsum_r;
  logic [23:0]          s2_colour_r;
  logic                 s2_clear_r, s2_done_r;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_prod_r   <= (DIM_W+DIM_W+1)'(s1_row_r) * (DIM_W+DIM_W+1)'(image_width_r);
      s2_colsum_r <= s1_colsum_r;
      s2_colour_r <= s1_in_range_r ? pal_rd_r : 24'd0;
      s2_clear_r  <= s1_clear_r;
      s2_done_r   <= s1_done_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: final address, bound check, output register
  // ---------------------------------------------------------------------------
  logic [DIM_W+DIM_W+1:0] s2_addr;
  logic                   s2_in_image;
  out_item_t              out_data_r;

  assign s2_addr     = {1'b0, s2_prod_r} + {{(DIM_W+1){1'b0}}, s2_colsum_r};
  assign s2_in_image = s2_addr < {2'b00, limit_r};

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_data_r.pixel_address <= s2_addr[ADDR_W-1:0];
      out_data_r.out_first     <= s2_colour_r[23:16];
      out_data_r.out_second    <= s2_colour_r[15:8];
      out_data_r.out_third     <= s2_colour_r[7:0];
      out_data_r.alpha         <= s2_clear_r ? ALPHA_CLEAR : ALPHA_OPAQUE;
      out_data_r.cell_done     <= s2_done_r;
    end
  end

  // stage valids; palette writes stop at the input, off-image pixels at stage 3
  logic s1_v_nxt, s2_v_nxt, out_v_nxt;

  always_comb begin
    s1_v_nxt  = s1_v_r;
    s2_v_nxt  = s2_v_r;
    out_v_nxt = out_v_r;
    if (in_acc) begin
      s1_v_nxt = (in_data.command == CMD_PIXEL);
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
    if (s1_go) begin
      s2_v_nxt = 1'b1;
    end else if (s2_go) begin
      s2_v_nxt = 1'b0;
    end
    if (s2_go) begin
      out_v_nxt = s2_in_image;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_empty_pipe_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_v_r && !s2_v_r) |-> in_ready)
    else $error("input stalled with empty pipe");

  a_write_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    wr_acc |=> !s1_v_r)
    else $error("palette write entered the pixel pipe");

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_acc && (in_col_r == TILE_LAST)) |=> (in_col_r == '0))
    else $error("in-tile column did not wrap");

  a_cell_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_acc && cell_done) |=>
      (in_col_r == '0 && in_row_r == '0 && tile_col_r == '0 && tile_row_r == '0))
    else $error("counters not cleared after last pixel of cell");

endmodule

`default_nettype wire

// ===== dv/tile_unswizzle_palette_expand_unit_tb.sv =====
`timescale 1ns / 1ps

module tile_unswizzle_palette_expand_unit_tb;
  import tupe_pkg::*;

  localparam int PAL_DEPTH    = 256;
  // three pipe stages in the block, plus some margin for dropped pixels
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int TIMEOUT_NS   = 2_000_000;

  // dut signals, all inputs known from time zero
  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tile_unswizzle_palette_expand_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the palette, key flag and position counters
  logic [23:0]          palette_copy [PAL_DEPTH];
  logic                 key_active = 1'b0;
  logic [TILE_BITS-1:0] sub_col    = '0;
  logic [TILE_BITS-1:0] sub_row    = '0;
  logic [TILES_W-1:0]   tile_col   = '0;
  logic [TILES_W-1:0]   tile_row   = '0;

  // predictor copy of the register file, starting at reset values
  logic [DIM_W-1:0]   img_w        = IMAGE_WIDTH_RST;
  logic [DIM_W-1:0]   img_h        = IMAGE_HEIGHT_RST;
  logic [DIM_W-1:0]   org_x        = '0;
  logic [DIM_W-1:0]   org_y        = '0;
  logic [TILES_W-1:0] tiles_across = TILES_RST;
  logic [TILES_W-1:0] tiles_down   = TILES_RST;

  // stimulus side bookkeeping: which palette entries hold a colour
  bit entry_loaded [PAL_DEPTH];
  int loaded_list [$];

  in_item_t  items_to_send [$];
  out_item_t expected_pixels [$];

  int items_taken    = 0;
  int pixels_seen    = 0;
  int pixels_dropped = 0;
  int cells_closed   = 0;
  int fail_count     = 0;
  int setting_count  = 0;

  // idling control
  bit quiet_tail  = 1'b0;
  bit hold_wanted = 1'b0;
  bit hold_used   = 1'b0;
  int send_gap    = 0;
  int recv_gap    = 0;
  int hold_left   = 0;

  logic      next_valid;
  in_item_t  next_item;
  logic      next_ready;
  out_item_t want;

  // expected behavior of one accepted item
  function automatic void unswizzle_step(in_item_t it);
    longint unsigned px;
    longint unsigned py;
    longint unsigned addr;
    longint unsigned bound;
    bit              last_col;
    bit              last_row;
    bit              done;
    out_item_t       res;
    logic [23:0]     rgb;
    if (it.command == CMD_PALETTE_WRITE) begin
      // all 256 indexes land inside the table at this depth
      palette_copy[it.index] = {it.color_first, it.color_second, it.color_third};
      if (it.index == 8'd0)
        key_active = (it.color_first == KEY_FIRST) && (it.color_second == KEY_SECOND) &&
                     (it.color_third == KEY_THIRD);
      return;
    end
    px    = tile_col;
    px    = px * 8 + sub_col;
    py    = tile_row;
    py    = py * 8 + sub_row;
    addr  = org_x;
    addr  = addr + org_y * img_w + px + py * img_w;
    bound = img_w;
    bound = bound * img_h;
    // a zero count or a counter left past the count both mean last tile
    last_col = (int'(tile_col) + 1) >= int'(tiles_across);
    last_row = (int'(tile_row) + 1) >= int'(tiles_down);
    done     = last_col && last_row && (sub_col == TILE_LAST) && (sub_row == TILE_LAST);
    // walk: pixel in tile row, rows of the tile, tiles across, tile rows
    if (sub_col != TILE_LAST) begin
      sub_col = sub_col + 1'b1;
    end else begin
      sub_col = '0;
      if (sub_row != TILE_LAST) begin
        sub_row = sub_row + 1'b1;
      end else begin
        sub_row = '0;
        if (!last_col) begin
          tile_col = tile_col + 1'b1;
        end else begin
          tile_col = '0;
          tile_row = last_row ? '0 : tile_row + 1'b1;
        end
      end
    end
    // outside the image: no item, the counters have moved on anyway
    if (addr >= bound) begin
      pixels_dropped++;
      return;
    end
    rgb               = palette_copy[it.index];
    res.pixel_address = addr[ADDR_W-1:0];
    res.out_first     = rgb[23:16];
    res.out_second    = rgb[15:8];
    res.out_third     = rgb[7:0];
    res.alpha         = (it.index == 8'd0 && key_active) ? ALPHA_CLEAR : ALPHA_OPAQUE;
    res.cell_done     = done;
    expected_pixels   = {expected_pixels, res};
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s expected 0x%0h got 0x%0h", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  function automatic void add_write(int idx, int c1, int c2, int c3);
    in_item_t it;
    it.command      = CMD_PALETTE_WRITE;
    it.index        = idx[7:0];
    it.color_first  = c1[7:0];
    it.color_second = c2[7:0];
    it.color_third  = c3[7:0];
    items_to_send   = {items_to_send, it};
    if (!entry_loaded[idx]) begin
      entry_loaded[idx] = 1'b1;
      loaded_list       = {loaded_list, idx};
    end
  endfunction

  function automatic void add_pixel(int idx);
    in_item_t it;
    it.command      = CMD_PIXEL;
    it.index        = idx[7:0];
    // colour fields mean nothing on a pixel, still wiggle them
    it.color_first  = 8'($urandom_range(0, 255));
    it.color_second = 8'($urandom_range(0, 255));
    it.color_third  = 8'($urandom_range(0, 255));
    items_to_send   = {items_to_send, it};
  endfunction

  // only indexes whose entry was loaded; index zero favored for the key check
  function automatic int pick_index();
    int idx;
    if (entry_loaded[0] && $urandom_range(0, 7) == 0)
      return 0;
    idx = $urandom_range(0, 255);
    if (!entry_loaded[idx])
      idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    return idx;
  endfunction

  // mostly pixels, with palette loads sprinkled in
  function automatic void add_random(int n);
    logic [23:0] key;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 4) == 0) begin
          // entry zero: exact key colour or a one-bit near miss
          key = {KEY_FIRST, KEY_SECOND, KEY_THIRD};
          if ($urandom_range(0, 1) == 1)
            key[$urandom_range(0, 23)] ^= 1'b1;
          add_write(0, key[23:16], key[15:8], key[7:0]);
        end else begin
          add_write($urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
        end
      end else begin
        add_pixel(pick_index());
      end
    end
  endfunction

  // six register writes back to back, block must be idle
  task automatic write_settings(input int w, input int h, input int x, input int y,
                                input int ta, input int td);
    logic [CFG_IDX_W-1:0] idx_list [6];
    int                   val_list [6];
    idx_list = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_CELL_X, CFG_CELL_Y,
                 CFG_CELL_TILES_ACROSS, CFG_CELL_TILES_DOWN};
    val_list = '{w, h, x, y, ta, td};
    for (int k = 0; k < 6; k++) begin
      @(posedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= idx_list[k];
      cfg_data <= val_list[k][CFG_DATA_W-1:0];
    end
    @(posedge clk);
    cfg_we       <= 1'b0;
    img_w        = w[DIM_W-1:0];
    img_h        = h[DIM_W-1:0];
    org_x        = x[DIM_W-1:0];
    org_y        = y[DIM_W-1:0];
    tiles_across = ta[TILES_W-1:0];
    tiles_down   = td[TILES_W-1:0];
    setting_count++;
  endtask

  // small images mostly, now and then a full-range value
  task automatic random_settings();
    int w;
    int h;
    int x;
    int y;
    int ta;
    int td;
    w  = $urandom_range(1, 48);
    h  = $urandom_range(1, 48);
    x  = $urandom_range(0, w);
    y  = $urandom_range(0, h);
    ta = $urandom_range(0, 4);
    td = $urandom_range(0, 4);
    if ($urandom_range(0, 5) == 0) w = $urandom_range(1, 32767);
    if ($urandom_range(0, 5) == 0) h = $urandom_range(1, 32767);
    if ($urandom_range(0, 5) == 0) x = $urandom_range(0, 32767);
    if ($urandom_range(0, 5) == 0) y = $urandom_range(0, 32767);
    if ($urandom_range(0, 5) == 0) ta = $urandom_range(0, 4095);
    if ($urandom_range(0, 5) == 0) td = $urandom_range(0, 4095);
    write_settings(w, h, x, y, ta, td);
  endtask

  // wait until everything sent has come back, then let the pipe empty out
  // since dropped pixels leave no item behind
  task automatic drain_block();
    while (items_to_send.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // input driver: valid stays up until taken, random gaps between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = in_valid;
      next_item  = in_data;
      if (in_valid && in_ready) begin
        unswizzle_step(in_data);
        items_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (items_to_send.size() != 0) begin
          if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            // this cycle idle, then a random idle gap
            send_gap = $urandom_range(0, 4);
          end else begin
            next_item  = items_to_send.pop_front();
            next_valid = 1'b1;
          end
        end
      end
      in_valid <= next_valid;
      in_data  <= next_item;
    end
  end

  // output monitor and ready driver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("item at address 0x%0h with nothing expected", out_data.pixel_address);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_address", want.pixel_address, out_data.pixel_address);
          check_field("out_first", want.out_first, out_data.out_first);
          check_field("out_second", want.out_second, out_data.out_second);
          check_field("out_third", want.out_third, out_data.out_third);
          check_field("alpha", want.alpha, out_data.alpha);
          check_field("cell_done", want.cell_done, out_data.cell_done);
          pixels_seen++;
          if (out_data.cell_done) cells_closed++;
        end
      end
      // one long hold-off so the pipe fills and in_ready drops
      if (hold_wanted && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        next_ready = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        recv_gap   = $urandom_range(0, 4);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_ready <= next_ready;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed, at reset settings: 8x8 image, one tile
    add_write(0, KEY_FIRST, KEY_SECOND, KEY_THIRD);
    add_write(255, 8'hFF, 8'hFF, 8'hFF);
    add_write(1, 8'h00, 8'h00, 8'h00);
    add_write(8'h80, 8'h80, 8'h55, 8'h01);
    add_write(8'h7F, 8'h7F, 8'hAA, 8'hFE);
    add_pixel(0);
    add_pixel(255);
    add_pixel(1);
    add_pixel(8'h80);
    add_pixel(8'h7F);
    // near miss on the key colour makes index zero opaque
    add_write(0, KEY_FIRST, KEY_SECOND, 8'hF9);
    add_pixel(0);
    add_pixel(1);
    add_write(0, 8'h00, KEY_SECOND, KEY_THIRD);
    add_pixel(0);
    // key colour back on entry zero
    add_write(0, KEY_FIRST, KEY_SECOND, KEY_THIRD);
    add_pixel(0);
    add_pixel(0);
    add_pixel(255);
    // rewrite a loaded entry and read it back
    add_write(255, 8'h01, 8'h80, 8'h00);
    add_pixel(255);
    add_pixel(8'h80);
    drain_block();

    // one-tile cell filling the image, running past cell ends
    write_settings(8, 8, 0, 0, 1, 1);
    add_random(130);
    drain_block();

    // every register at its top value: cell sits fully outside the image
    write_settings(32767, 32767, 32767, 32767, 4095, 4095);
    add_random(40);
    drain_block();

    // one-pixel image, zero tile counts act as one
    write_settings(1, 1, 0, 0, 0, 0);
    add_random(80);
    drain_block();

    // offset cell, rows overflow to the next line and the bottom is clipped
    write_settings(20, 15, 5, 3, 3, 2);
    add_random(120);
    drain_block();

    // big image, receiver holds off while the sender keeps going
    write_settings(100, 100, 0, 0, 2, 2);
    hold_wanted = 1'b1;
    add_random(350);
    drain_block();

    // single-row wide image: only the top pixel row survives
    write_settings(32767, 1, 0, 0, 4095, 1);
    add_random(60);
    drain_block();

    // one-pixel-wide tall image, cell counters left past the new counts
    write_settings(1, 32767, 0, 100, 1, 4095);
    add_random(60);
    drain_block();

    repeat (8) begin
      random_settings();
      add_random($urandom_range(40, 100));
      drain_block();
    end

    // last stretch with both sides always ready
    quiet_tail = 1'b1;
    write_settings(16, 16, 0, 0, 2, 2);
    add_random(100);
    drain_block();

    $display("ran %0d items under %0d register settings, %0d pixels checked, %0d clipped",
             items_taken, setting_count, pixels_seen, pixels_dropped);
    $display("%0d cell ends seen, one long output hold-off", cells_closed);
    if (fail_count == 0) begin
      $display("PASS tile_unswizzle_palette_expand_unit");
    end else begin
      $display("FAIL tile_unswizzle_palette_expand_unit");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL tile_unswizzle_palette_expand_unit");
    $finish;
  end

endmodule
